/* rtl/bda_pkg.sv */
// Shared types, constants and helpers for the button debounce and auto-repeat block.
`timescale 1ns / 1ps

package bda_pkg;

   localparam int MASK_WIDTH = 8;
   localparam int INDEX_WIDTH = 3;
   localparam int TIME_WIDTH = 32;
   localparam int COUNT_WIDTH = 4;
   localparam int INTERVAL_WIDTH = 16;
   localparam int DEF_NUM_BUTTONS = 8;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_DEBOUNCE_SAMPLES = 2'd0;
   localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd1;
   localparam logic [1:0] REG_REPEAT_ENABLE = 2'd2;

   localparam logic [COUNT_WIDTH-1:0] RST_DEBOUNCE_SAMPLES = 4'd3;
   localparam logic [INTERVAL_WIDTH-1:0] RST_REPEAT_INTERVAL = 16'd150;
   localparam logic [MASK_WIDTH-1:0] RST_REPEAT_ENABLE = 8'd15;
   localparam logic [INTERVAL_WIDTH-1:0] MIN_INTERVAL = 16'd50;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]    debounce_samples;
      logic [INTERVAL_WIDTH-1:0] repeat_interval_ms;
      logic [MASK_WIDTH-1:0]     repeat_enable_mask;
   } bda_cfg_type;

   typedef struct packed {
      logic                   valid;
      logic [INDEX_WIDTH-1:0] button_index;
      logic                   is_repeat;
   } bda_evt_type;

   // index of the lowest set bit, zero for an empty mask
   function automatic logic [INDEX_WIDTH-1:0] lowest_index(input logic [MASK_WIDTH-1:0] m);
      logic [INDEX_WIDTH-1:0] idx;
      idx = '0;
      for (int i = MASK_WIDTH - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = INDEX_WIDTH'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/bda_csr.sv */
// Configuration registers of the debounce block behind an APB-style port.
`timescale 1ns / 1ps

module bda_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bda_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [bda_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [bda_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output bda_pkg::bda_cfg_type                cfg
);
   import bda_pkg::*;

   bda_cfg_type cfg_ff;
   bda_cfg_type cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;
   logic [INTERVAL_WIDTH-1:0] interval_wr;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx = csr_paddr[3:2];
   assign interval_wr = csr_pwdata[INTERVAL_WIDTH-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE_SAMPLES: cfg_in.debounce_samples = csr_pwdata[COUNT_WIDTH-1:0];
            REG_REPEAT_INTERVAL: begin
               // clamp short intervals
               cfg_in.repeat_interval_ms = (interval_wr < MIN_INTERVAL) ? MIN_INTERVAL
                                                                        : interval_wr;
            end
            REG_REPEAT_ENABLE: cfg_in.repeat_enable_mask = csr_pwdata[MASK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE_SAMPLES:
            csr_prdata = CSR_DATA_WIDTH'(cfg_ff.debounce_samples);
         REG_REPEAT_INTERVAL:
            csr_prdata = CSR_DATA_WIDTH'(cfg_ff.repeat_interval_ms);
         REG_REPEAT_ENABLE:
            csr_prdata = CSR_DATA_WIDTH'(cfg_ff.repeat_enable_mask);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_samples <= RST_DEBOUNCE_SAMPLES;
         cfg_ff.repeat_interval_ms <= RST_REPEAT_INTERVAL;
         cfg_ff.repeat_enable_mask <= RST_REPEAT_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/bda_core.sv */
// Debounce state and auto-repeat timer: one poll is processed per step.
`timescale 1ns / 1ps

module bda_core #(
   parameter int NUM_BUTTONS = bda_pkg::DEF_NUM_BUTTONS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [bda_pkg::MASK_WIDTH-1:0]      raw_mask,
   input  logic [bda_pkg::TIME_WIDTH-1:0]      time_ms,
   input  bda_pkg::bda_cfg_type                cfg,
   output bda_pkg::bda_evt_type                evt
);
   import bda_pkg::*;

   localparam int USED_BUTTONS = (NUM_BUTTONS >= MASK_WIDTH) ? MASK_WIDTH : NUM_BUTTONS;
   localparam logic [MASK_WIDTH-1:0] BUTTON_MASK = MASK_WIDTH'((1 << USED_BUTTONS) - 1);

   logic [MASK_WIDTH-1:0]  stable_mask_ff, stable_mask_in;
   logic [MASK_WIDTH-1:0]  last_raw_ff, last_raw_in;
   logic [COUNT_WIDTH-1:0] same_count_ff, same_count_in;
   logic                   holding_ff, holding_in;
   logic [INDEX_WIDTH-1:0] held_button_ff, held_button_in;
   logic [TIME_WIDTH-1:0]  last_time_ff, last_time_in;

   logic [MASK_WIDTH-1:0]  raw;
   logic [TIME_WIDTH-1:0]  elapsed;
   logic                   repeat_hit;
   logic                   settled;
   logic [INDEX_WIDTH-1:0] idx;
   logic                   idx_en;

   assign raw = raw_mask & BUTTON_MASK;
   assign elapsed = time_ms - last_time_ff;
   assign repeat_hit = holding_ff && (elapsed >= TIME_WIDTH'(cfg.repeat_interval_ms));
   assign idx = lowest_index(raw);
   assign idx_en = cfg.repeat_enable_mask[idx];

   always_comb begin
      stable_mask_in = stable_mask_ff;
      last_raw_in = last_raw_ff;
      same_count_in = same_count_ff;
      holding_in = holding_ff;
      held_button_in = held_button_ff;
      last_time_in = last_time_ff;
      evt = '0;

      if (raw == last_raw_ff) begin
         if (same_count_ff < cfg.debounce_samples) begin
            same_count_in = same_count_ff + 1'b1;
         end
      end else begin
         last_raw_in = raw;
         same_count_in = '0;
      end
      settled = !(same_count_in < cfg.debounce_samples);

      if (!settled || raw == stable_mask_ff) begin
         if (settled) begin
            stable_mask_in = raw;
         end
         if (repeat_hit) begin
            evt.valid = 1'b1;
            evt.button_index = held_button_ff;
            evt.is_repeat = 1'b1;
            last_time_in = time_ms;
         end
      end else begin
         stable_mask_in = raw;
         if (raw == '0) begin
            // release to idle: stop repeating
            holding_in = 1'b0;
         end else begin
            evt.valid = 1'b1;
            evt.button_index = idx;
            evt.is_repeat = 1'b0;
            if (stable_mask_ff == '0) begin
               holding_in = idx_en;
               if (idx_en) begin
                  held_button_in = idx;
                  last_time_in = time_ms;
               end
            end else begin
               holding_in = idx_en;
               held_button_in = idx;
               last_time_in = time_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_mask_ff <= '0;
         last_raw_ff <= '0;
         same_count_ff <= '0;
         holding_ff <= 1'b0;
         held_button_ff <= '0;
         last_time_ff <= '0;
      end else if (step) begin
         stable_mask_ff <= stable_mask_in;
         last_raw_ff <= last_raw_in;
         same_count_ff <= same_count_in;
         holding_ff <= holding_in;
         held_button_ff <= held_button_in;
         last_time_ff <= last_time_in;
      end
   end

endmodule

/* rtl/button_debounce_autorepeat.sv */
// A poll word is held in the input register and its event word in the event register.
// Throughput: one poll word per cycle unless rsp_tready stalls the event register;
// the state update is a single pass between the input and the event register.
// Polls that cause no event are dropped at the event register.
// Reset (synchronous): stable mask, counters and repeat timer clear to zero and the
// registers return to debounce 3, interval 150 ms, repeat enable 0x0F.
`timescale 1ns / 1ps

module button_debounce_autorepeat #(
   parameter int NUM_BUTTONS = bda_pkg::DEF_NUM_BUTTONS
) (
   input  logic                                clock,
   input  logic                                reset,
   // poll word: [7:0] raw_mask, [39:8] time_ms
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [39:0]                         req_tdata,
   // event word: [2:0] button_index, [7:3] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,
   // [0] is_repeat
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bda_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [bda_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [bda_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import bda_pkg::*;

   bda_cfg_type cfg;
   bda_evt_type evt;

   logic                   in_valid_ff, in_valid_in;
   logic [MASK_WIDTH-1:0]  in_raw_ff;
   logic [TIME_WIDTH-1:0]  in_time_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [INDEX_WIDTH-1:0] out_index_ff;
   logic                   out_repeat_ff;
   logic                   proc_go;
   logic                   req_take;

   bda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bda_core #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (proc_go),
      .raw_mask (in_raw_ff),
      .time_ms  (in_time_ff),
      .cfg      (cfg),
      .evt      (evt)
   );

   // advance the held poll once the event register is free
   assign proc_go = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_go;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (proc_go) begin
         out_valid_in = evt.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_raw_ff <= req_tdata[MASK_WIDTH-1:0];
         in_time_ff <= req_tdata[MASK_WIDTH +: TIME_WIDTH];
      end
      if (proc_go) begin
         out_index_ff <= evt.button_index;
         out_repeat_ff <= evt.is_repeat;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'b0, out_index_ff};
   assign rsp_tuser = out_repeat_ff;

endmodule
